### rtl/lnr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lnr_pkg
// Types and constants shared by the leaky neuron with refractory window.
// ----------------------------------------------------------------------------
package lnr_pkg;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned TICKS_W     = 10;
	localparam int unsigned PENALTY_W   = 15;

	localparam logic [CFG_INDEX_W-1:0] REG_FIRE_THRESHOLD = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PSP_FLOOR      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PSP_DECAY      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CALCIUM_DECAY  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CALCIUM_STEP   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_REFRACTORY     = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_LEARNING_ON    = 3'd6;

	localparam logic [1:0] FUNC_SPIKE = 2'd0;
	localparam logic [1:0] FUNC_TICK  = 2'd1;
	localparam logic [1:0] FUNC_LOAD  = 2'd2;

	localparam logic [TICKS_W-1:0] TICKS_MAX = 10'd1023;

	typedef struct packed {
		logic signed [15:0]   fire_threshold;
		logic signed [15:0]   psp_floor;
		logic [15:0]          psp_decay_factor;
		logic [15:0]          calcium_decay_factor;
		logic [15:0]          calcium_step;
		logic [TICKS_W-1:0]   refractory_ticks;
		logic                 learning_on;
	} cfg_t;

	typedef struct packed {
		logic [1:0]           func;
		logic signed [15:0]   amount;
		logic [7:0]           entry_index;
	} item_t;

	typedef struct packed {
		logic                 fired;
		logic signed [15:0]   membrane_level;
		logic [15:0]          calcium_level;
	} result_t;

endpackage
`default_nettype wire

### rtl/lnr_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lnr_cfg_regs
// Configuration register bank with a calcium clear pulse on learning enable.
// ----------------------------------------------------------------------------
module lnr_cfg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [lnr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [lnr_pkg::CFG_DATA_W-1:0]     cfg_data,
	output lnr_pkg::cfg_t                           cfg,
	output logic                                    calcium_clear
);
	import lnr_pkg::*;

	cfg_t cfg_q;

	assign cfg = cfg_q;
	assign calcium_clear = cfg_we && (cfg_index == REG_LEARNING_ON) && cfg_data[0]
		&& !cfg_q.learning_on;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FIRE_THRESHOLD: cfg_q.fire_threshold <= $signed(cfg_data);
				REG_PSP_FLOOR:      cfg_q.psp_floor <= $signed(cfg_data);
				REG_PSP_DECAY:      cfg_q.psp_decay_factor <= cfg_data;
				REG_CALCIUM_DECAY:  cfg_q.calcium_decay_factor <= cfg_data;
				REG_CALCIUM_STEP:   cfg_q.calcium_step <= cfg_data;
				REG_REFRACTORY:     cfg_q.refractory_ticks <= cfg_data[TICKS_W-1:0];
				REG_LEARNING_ON:    cfg_q.learning_on <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/lnr_penalty_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lnr_penalty_mem
// Refractory penalty table with registered read, write bypass and valid bits.
// ----------------------------------------------------------------------------
module lnr_penalty_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               wr_en,
	input  wire logic [AW-1:0]                      wr_addr,
	input  wire logic [lnr_pkg::PENALTY_W-1:0]      wr_data,
	input  wire logic [AW-1:0]                      rd_addr,
	output logic [lnr_pkg::PENALTY_W-1:0]           rd_data
);
	import lnr_pkg::*;

	logic [PENALTY_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]     valid_q;
	logic [PENALTY_W-1:0] rd_q;
	logic                 rd_valid_q;
	logic                 byp_q;
	logic [PENALTY_W-1:0] byp_data_q;

	// Entries never loaded read as zero; a load to the address being read wins.
	assign rd_data = byp_q ? byp_data_q : (rd_valid_q ? rd_q : '0);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
		byp_data_q <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
			byp_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
			byp_q <= wr_en && (wr_addr == rd_addr);
		end
	end

endmodule
`default_nettype wire

### rtl/lnr_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lnr_core
// Neuron state and its spike, timestep and decay update, computed combinationally and registered.
// ----------------------------------------------------------------------------
module lnr_core #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  lnr_pkg::cfg_t                           cfg,
	input  wire logic                               calcium_clear,
	input  lnr_pkg::item_t                          item,
	input  wire logic                               go,
	input  wire logic [lnr_pkg::PENALTY_W-1:0]      penalty,
	output lnr_pkg::result_t                        res,
	output logic [AW-1:0]                           rd_addr
);
	import lnr_pkg::*;

	localparam logic [AW-1:0]      LAST_ADDR  = AW'(DEPTH - 1);
	localparam logic [TICKS_W-1:0] LAST_TICKS = TICKS_W'(DEPTH - 1);

	logic signed [15:0]   psp_q;
	logic [15:0]          ca_q;
	logic [TICKS_W-1:0]   ticks_q;

	logic                 is_spike;
	logic                 is_tick;
	logic signed [16:0]   spike_sum;
	logic signed [15:0]   spike_sat;
	logic signed [15:0]   spike_next;
	logic                 refr;
	logic signed [16:0]   pot_diff;
	logic signed [15:0]   pot_raw;
	logic signed [15:0]   pot_v;
	logic                 fire;
	logic [15:0]          psp_mag;
	logic [31:0]          psp_prod;
	logic [15:0]          psp_dec_mag;
	logic signed [15:0]   psp_dec;
	logic [16:0]          ca_sum;
	logic [15:0]          ca_fire;
	logic [31:0]          ca_prod_keep;
	logic [31:0]          ca_prod_fire;
	logic [15:0]          ca_out;
	logic [15:0]          ca_tick_next;
	logic signed [15:0]   psp_tick_next;
	logic [TICKS_W-1:0]   ticks_d;

	assign is_spike = go && (item.func == FUNC_SPIKE);
	assign is_tick  = go && (item.func == FUNC_TICK);

	always_comb begin
		spike_sum = {psp_q[15], psp_q} + {item.amount[15], item.amount};
		if (spike_sum > 17'sd32767) begin
			spike_sat = 16'sh7FFF;
		end else if (spike_sum < -17'sd32768) begin
			spike_sat = 16'sh8000;
		end else begin
			spike_sat = spike_sum[15:0];
		end
		spike_next = (spike_sat < cfg.psp_floor) ? cfg.psp_floor : spike_sat;
	end

	always_comb begin
		refr = (ticks_q <= cfg.refractory_ticks);
		pot_diff = {psp_q[15], psp_q} - $signed({2'b00, penalty});
		if (pot_diff < -17'sd32768) begin
			pot_raw = 16'sh8000;
		end else begin
			pot_raw = pot_diff[15:0];
		end
		pot_v = refr ? 16'sd0 : pot_raw;
		fire = (pot_v > cfg.fire_threshold);
	end

	// Decay of the unchanged total and of both calcium candidates runs in parallel
	// with the threshold compare; the firing decision only selects.
	always_comb begin
		psp_mag = psp_q[15] ? (~psp_q + 16'd1) : psp_q;
		psp_prod = psp_mag * cfg.psp_decay_factor;
		psp_dec_mag = psp_prod[31:16];
		psp_dec = psp_q[15] ? -$signed(psp_dec_mag) : $signed(psp_dec_mag);
		psp_tick_next = (refr || fire) ? 16'sd0 : psp_dec;

		ca_sum = {1'b0, ca_q} + {1'b0, cfg.calcium_step};
		ca_fire = ca_sum[16] ? 16'hFFFF : ca_sum[15:0];
		ca_prod_keep = ca_q * cfg.calcium_decay_factor;
		ca_prod_fire = ca_fire * cfg.calcium_decay_factor;
		ca_out = fire ? ca_fire : ca_q;
		ca_tick_next = fire ? ca_prod_fire[31:16] : ca_prod_keep[31:16];
	end

	always_comb begin
		if (!is_tick) begin
			ticks_d = ticks_q;
		end else if (fire) begin
			ticks_d = TICKS_W'(1);
		end else if (ticks_q == TICKS_MAX) begin
			ticks_d = ticks_q;
		end else begin
			ticks_d = ticks_q + TICKS_W'(1);
		end
		rd_addr = (ticks_d > LAST_TICKS) ? LAST_ADDR : ticks_d[AW-1:0];
	end

	assign res.fired = fire;
	assign res.membrane_level = fire ? 16'sd0 : pot_v;
	assign res.calcium_level = ca_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psp_q <= '0;
			ca_q <= '0;
			ticks_q <= TICKS_MAX;
		end else begin
			ticks_q <= ticks_d;
			if (is_spike) begin
				psp_q <= spike_next;
			end else if (is_tick) begin
				psp_q <= psp_tick_next;
			end
			if (calcium_clear) begin
				ca_q <= '0;
			end else if (is_tick) begin
				ca_q <= ca_tick_next;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/leaky_neuron_with_refractory.sv
`default_nettype none
// ----------------------------------------------------------------------------
// leaky_neuron_with_refractory
// A timestep beat passes the input register and then the output register before its result is on m_tvalid.
// Throughput: one beat per cycle; a result waiting on m_tready holds the next
// timestep beat in the input register, and that stalls the input.
// The penalty table is addressed with the next tick count from a registered memory port.
// Reset clears the valid flags, neuron state and configuration, saturates the tick
// counter, and makes every penalty entry read as zero until it is loaded.
// ----------------------------------------------------------------------------
module leaky_neuron_with_refractory #(
	parameter int unsigned PENALTY_DEPTH = 64
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [23:0]                        s_tdata,  // amount, entry_index
	input  wire logic [1:0]                         s_tuser,  // func
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [39:0]                             m_tdata,  // fired, membrane_level,
	                                                          // calcium_level, zero fill
	input  wire logic                               cfg_we,
	input  wire logic [lnr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [lnr_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import lnr_pkg::*;

	localparam int unsigned AW = $clog2(PENALTY_DEPTH);

	cfg_t       cfg;
	logic       calcium_clear;
	logic       item_valid_s1;
	item_t      item_s1;
	logic       is_tick_s1;
	logic       out_free;
	logic       go;
	logic       wr_en;
	logic [AW-1:0]        rd_addr;
	logic [PENALTY_W-1:0] penalty;
	result_t    res;
	logic       m_valid_q;
	result_t    m_res_q;

	lnr_cfg_regs u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cfg           (cfg),
		.calcium_clear (calcium_clear)
	);

	assign is_tick_s1 = (item_s1.func == FUNC_TICK);
	assign out_free = !m_valid_q || m_tready;
	assign go = item_valid_s1 && (!is_tick_s1 || out_free);
	assign s_tready = !item_valid_s1 || go;
	assign wr_en = go && (item_s1.func == FUNC_LOAD)
		&& ({1'b0, item_s1.entry_index} < 9'(PENALTY_DEPTH));

	lnr_penalty_mem #(
		.DEPTH (PENALTY_DEPTH),
		.AW    (AW)
	) u_pmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (item_s1.entry_index[AW-1:0]),
		.wr_data (item_s1.amount[PENALTY_W-1:0]),
		.rd_addr (rd_addr),
		.rd_data (penalty)
	);

	lnr_core #(
		.DEPTH (PENALTY_DEPTH),
		.AW    (AW)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.calcium_clear (calcium_clear),
		.item          (item_s1),
		.go            (go),
		.penalty       (penalty),
		.res           (res),
		.rd_addr       (rd_addr)
	);

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.func <= s_tuser;
			item_s1.amount <= $signed(s_tdata[15:0]);
			item_s1.entry_index <= s_tdata[23:16];
		end
		if (go && is_tick_s1) begin
			m_res_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				item_valid_s1 <= 1'b1;
			end else if (go) begin
				item_valid_s1 <= 1'b0;
			end
			if (go && is_tick_s1) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {7'd0, m_res_q.calcium_level, m_res_q.membrane_level, m_res_q.fired};

endmodule
`default_nettype wire
